FILE: design/dfc_pkg.sv
// Shared types and constants for the double / 48-bit float converter.
package dfc_pkg;

   // Class of an item as it moves down the pipeline
   typedef enum logic [2:0] {
      CLS_NORMAL,
      CLS_ZERO,
      CLS_SAT_POS,
      CLS_SAT_NEG,
      CLS_FLUSH
   } cls_type;

   localparam int MANT_W = 41;

   // Double exponent field of infinity and NaN
   localparam logic [10:0] EXP_SPECIAL = 11'h7FF;
   // Biased double exponent range that fits the 7-bit exponent field
   localparam logic [11:0] EXP_MIN = 12'd958;
   localparam logic [11:0] EXP_MAX = 12'd1085;
   // Offset from (top bit + 48-bit exponent field) to the double exponent
   localparam logic [10:0] REV_BIAS = 11'd919;
   // Shift that puts the top mantissa bit on the hidden bit
   localparam logic [5:0] SHIFT_BASE = 6'd52;

   localparam logic [63:0] POS_MAX_WORD = 64'h0000_FEFF_FFFF_FFFF;
   localparam logic [63:0] NEG_MAX_WORD = 64'h0000_FF00_0000_0000;
   localparam logic [63:0] ZERO_WORD = 64'h0000_8000_0000_0000;

   // Payload after unpack and round / negate
   typedef struct packed {
      logic              kind;
      logic              neg;
      cls_type           cls;
      logic [10:0]       bexp;
      logic [6:0]        xfield;
      logic [MANT_W-1:0] mag;
   } s1_type;

   // Payload after range check / leading-one search
   typedef struct packed {
      logic              kind;
      logic              neg;
      cls_type           cls;
      logic [6:0]        xfield;
      logic [5:0]        top;
      logic [10:0]       bexp;
      logic [MANT_W-1:0] mag;
   } s2_type;

endpackage

FILE: design/dfc_unpack.sv
// First stage: field unpack, class decode and the shared round / negate adder.
module dfc_unpack (
   input  logic           clock,
   input  logic           reset,
   input  logic           adv,
   input  logic           in_valid,
   input  logic           in_kind,
   input  logic [63:0]    in_value,
   output logic           valid_ff,
   output dfc_pkg::s1_type data_ff
);
   import dfc_pkg::*;

   logic              valid_in;
   s1_type            data_in;
   logic              neg;
   logic [10:0]       bexp;
   logic [51:0]       frac;
   logic [MANT_W-1:0] m;
   logic [MANT_W-1:0] add_a;
   logic              inv;
   logic              cin;

   assign neg  = in_value[63];
   assign bexp = in_value[62:52];
   assign frac = in_value[51:0];
   assign m    = in_value[MANT_W-1:0];

   // Pick adder operands: round-up for forward, two's complement magnitude for reverse
   always_comb begin
      if (in_kind) begin
         add_a = m;
         inv   = m[MANT_W-1];
         cin   = m[MANT_W-1];
      end else begin
         add_a = {2'b01, frac[51:13]};
         inv   = 1'b0;
         cin   = frac[12];
      end
   end

   // Classify and build the stage payload
   always_comb begin
      data_in.kind   = in_kind;
      data_in.bexp   = bexp;
      data_in.xfield = in_value[47:41];
      data_in.mag    = (add_a ^ {MANT_W{inv}}) + {{(MANT_W-1){1'b0}}, cin};
      if (in_kind) begin
         data_in.neg = m[MANT_W-1];
         data_in.cls = (m == '0) ? CLS_ZERO : CLS_NORMAL;
      end else begin
         data_in.neg = neg;
         if (bexp == EXP_SPECIAL) begin
            data_in.cls = ((frac != '0) || !neg) ? CLS_SAT_POS : CLS_SAT_NEG;
         end else if (bexp == '0) begin
            // denormals always lie below the smallest exponent
            data_in.cls = (frac == '0) ? CLS_ZERO : CLS_FLUSH;
         end else begin
            data_in.cls = CLS_NORMAL;
         end
      end
   end

   assign valid_in = in_valid;

   // Advance the stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: design/dfc_range.sv
// Second stage: rounding carry, exponent range check and leading-one search.
module dfc_range (
   input  logic           clock,
   input  logic           reset,
   input  logic           adv,
   input  logic           in_valid,
   input  dfc_pkg::s1_type in_data,
   output logic           valid_ff,
   output dfc_pkg::s2_type data_ff
);
   import dfc_pkg::*;

   s2_type      data_in;
   logic        carry;
   logic [11:0] be;
   logic [11:0] xdiff;

   function automatic logic [5:0] top_bit(input logic [MANT_W-1:0] v);
      logic [5:0] p;
      p = '0;
      for (int i = 0; i < MANT_W; i++) begin
         if (v[i]) begin
            p = 6'(i);
         end
      end
      return p;
   endfunction

   assign carry = in_data.mag[MANT_W-1];
   assign be    = {1'b0, in_data.bexp} + {11'b0, carry};
   assign xdiff = be - EXP_MIN;

   // Renormalize a rounding carry and check the exponent range
   always_comb begin
      data_in.kind   = in_data.kind;
      data_in.neg    = in_data.neg;
      data_in.cls    = in_data.cls;
      data_in.top    = top_bit(in_data.mag);
      data_in.bexp   = 11'({5'b0, data_in.top} + {4'b0, in_data.xfield} + REV_BIAS);
      data_in.xfield = xdiff[6:0];
      data_in.mag    = in_data.mag;
      if (!in_data.kind) begin
         if (carry) begin
            data_in.mag = {2'b01, {(MANT_W-2){1'b0}}};
         end
         if (in_data.cls == CLS_NORMAL) begin
            if (be < EXP_MIN) begin
               data_in.cls = CLS_FLUSH;
            end else if (be > EXP_MAX) begin
               data_in.cls = in_data.neg ? CLS_SAT_NEG : CLS_SAT_POS;
            end
         end
      end
   end

   // Advance the stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: design/dfc_pack.sv
// Third stage: normalizing shift, mantissa sign and result assembly.
module dfc_pack (
   input  logic           clock,
   input  logic           reset,
   input  logic           adv,
   input  logic           in_valid,
   input  dfc_pkg::s2_type in_data,
   output logic           valid_ff,
   output logic [63:0]    result_ff,
   output logic           saturated_ff,
   output logic           flushed_ff
);
   import dfc_pkg::*;

   logic [63:0]       result_in;
   logic              saturated_in;
   logic              flushed_in;
   logic [5:0]        sh;
   logic [52:0]       wide;
   logic [MANT_W-1:0] mant;

   assign sh   = SHIFT_BASE - in_data.top;
   assign wide = {12'b0, in_data.mag} << sh;
   assign mant = in_data.neg ? (~{1'b0, in_data.mag[MANT_W-2:0]} + 41'd1)
                             : {1'b0, in_data.mag[MANT_W-2:0]};

   // Assemble the result word
   always_comb begin
      result_in    = '0;
      saturated_in = 1'b0;
      flushed_in   = 1'b0;
      if (in_data.kind) begin
         if (in_data.cls != CLS_ZERO) begin
            result_in = {in_data.neg, in_data.bexp, wide[51:0]};
         end
      end else begin
         unique case (in_data.cls)
            CLS_NORMAL:  result_in = {16'b0, in_data.xfield, mant};
            CLS_ZERO:    result_in = ZERO_WORD;
            CLS_SAT_POS: begin
               result_in    = POS_MAX_WORD;
               saturated_in = 1'b1;
            end
            CLS_SAT_NEG: begin
               result_in    = NEG_MAX_WORD;
               saturated_in = 1'b1;
            end
            CLS_FLUSH:   flushed_in = 1'b1;
            default:     result_in = '0;
         endcase
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         result_ff    <= result_in;
         saturated_ff <= saturated_in;
         flushed_ff   <= flushed_in;
      end
   end

endmodule

FILE: design/double_float48_converter_core.sv
// Top level of the double / 48-bit float converter pipeline.
//
// Usage:
//   req_kind selects the direction: 0 turns IEEE double bits in req_value into
//   a 48-bit word (7-bit exponent biased by 64, 41-bit two's complement
//   mantissa rounded half-up), 1 expands the 48-bit word in req_value[47:0]
//   into exact double bits. Each item gives one result on rsp_result with
//   rsp_saturated (overflow, infinity, NaN) and rsp_flushed (tiny input).
// Timing:
//   Three register stages (unpack and round, range check and leading-one
//   search, shift and assemble); an accepted item passes through all three
//   in that order to rsp_result. One item per cycle is accepted at full
//   rate while rsp_stall is low, since each stage refills as it drains.
// Reset:
//   A synchronous reset empties all stages; no result is valid afterwards.
// Stall:
//   When rsp_stall holds a result, stages behind it keep filling bubbles;
//   req_stall rises only when all three stages hold items.
module double_float48_converter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [63:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result,
   output logic        rsp_saturated,
   output logic        rsp_flushed
);
   import dfc_pkg::*;

   logic   s1_valid;
   logic   s2_valid;
   s1_type s1_data;
   s2_type s2_data;
   logic   adv1;
   logic   adv2;
   logic   adv3;

   // Advance a stage when it is empty or the stage after it moves
   assign adv3      = !rsp_valid || !rsp_stall;
   assign adv2      = !s2_valid || adv3;
   assign adv1      = !s1_valid || adv2;
   assign req_stall = !adv1;

   dfc_unpack u_unpack (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv1),
      .in_valid (req_valid),
      .in_kind  (req_kind),
      .in_value (req_value),
      .valid_ff (s1_valid),
      .data_ff  (s1_data)
   );

   dfc_range u_range (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv2),
      .in_valid (s1_valid),
      .in_data  (s1_data),
      .valid_ff (s2_valid),
      .data_ff  (s2_data)
   );

   dfc_pack u_pack (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv3),
      .in_valid     (s2_valid),
      .in_data      (s2_data),
      .valid_ff     (rsp_valid),
      .result_ff    (rsp_result),
      .saturated_ff (rsp_saturated),
      .flushed_ff   (rsp_flushed)
   );

   // Saturation and flush never come together
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_saturated && rsp_flushed))
      else $error("saturated and flushed both set");

   // A flushed item gives the all-zero word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_flushed |-> rsp_result == 64'd0)
      else $error("flushed result not zero");

   // A saturated item gives one of the two extreme words
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_result == POS_MAX_WORD || rsp_result == NEG_MAX_WORD)
      else $error("saturated result not an extreme");

   // Input stalls only when every stage is full and the output is held
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid && s2_valid && rsp_valid && rsp_stall)
      else $error("input stalled with room in the pipeline");

endmodule
